// File: rtl/core/rks_pkg.sv
// Package of shared constants, types and the distance-bin table of the radial smoother.
package rks_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_RADIUS  = 10;
    localparam int WEIGHT_BINS = 44;
    localparam int PIXEL_BITS  = 24;
    localparam int WEIGHT_BITS = 18;

    localparam int LINE_SLOTS  = 2 * MAX_RADIUS + 1;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int SLOT_BITS   = $clog2(LINE_SLOTS);
    localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
    localparam int BIN_BITS    = $clog2(WEIGHT_BINS);
    localparam int PROD_BITS   = PIXEL_BITS + WEIGHT_BITS + 1;
    localparam int ACC_BITS    = PROD_BITS + 9;
    localparam int RND_BITS    = ACC_BITS - WEIGHT_BITS;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Bin of a squared distance; only distances that occur in the disc are asked for.
    function automatic logic [BIN_BITS-1:0] bin_of_d2(input logic [7:0] d2);
        logic [BIN_BITS-1:0] b;
        b = '0;
        unique case (d2)
            8'd0:  b = 6'd0;   8'd1:  b = 6'd1;   8'd2:  b = 6'd2;   8'd4:  b = 6'd3;
            8'd5:  b = 6'd4;   8'd8:  b = 6'd5;   8'd9:  b = 6'd6;   8'd10: b = 6'd7;
            8'd13: b = 6'd8;   8'd16: b = 6'd9;   8'd17: b = 6'd10;  8'd18: b = 6'd11;
            8'd20: b = 6'd12;  8'd25: b = 6'd13;  8'd26: b = 6'd14;  8'd29: b = 6'd15;
            8'd32: b = 6'd16;  8'd34: b = 6'd17;  8'd36: b = 6'd18;  8'd37: b = 6'd19;
            8'd40: b = 6'd20;  8'd41: b = 6'd21;  8'd45: b = 6'd22;  8'd49: b = 6'd23;
            8'd50: b = 6'd24;  8'd52: b = 6'd25;  8'd53: b = 6'd26;  8'd58: b = 6'd27;
            8'd61: b = 6'd28;  8'd64: b = 6'd29;  8'd65: b = 6'd30;  8'd68: b = 6'd31;
            8'd72: b = 6'd32;  8'd73: b = 6'd33;  8'd74: b = 6'd34;  8'd80: b = 6'd35;
            8'd81: b = 6'd36;  8'd82: b = 6'd37;  8'd85: b = 6'd38;  8'd89: b = 6'd39;
            8'd90: b = 6'd40;  8'd97: b = 6'd41;  8'd98: b = 6'd42;  8'd100: b = 6'd43;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/rks_if.sv
// Handshake interfaces for the input and result words of the radial smoother.
interface rks_in_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [5:0]                       weight_index;
    logic [rks_pkg::WEIGHT_BITS-1:0]  weight_value;
    logic signed [rks_pkg::PIXEL_BITS-1:0] pixel_value;
    logic                             frame_start;

    modport source (output valid, op, weight_index, weight_value, pixel_value, frame_start,
                    input ready);
    modport sink   (input valid, op, weight_index, weight_value, pixel_value, frame_start,
                    output ready);
endinterface

interface rks_out_if;
    logic                             valid;
    logic                             ready;
    logic [11:0]                      out_col;
    logic [11:0]                      out_row;
    logic signed [rks_pkg::PIXEL_BITS-1:0] smoothed_value;
    logic                             frame_last;

    modport source (output valid, out_col, out_row, smoothed_value, frame_last, input ready);
    modport sink   (input valid, out_col, out_row, smoothed_value, frame_last, output ready);
endinterface

// File: rtl/core/radial_kernel_image_smooth.sv
// Top level of the radial smoother: line stores, weight table and tap sequencer.
//
// Usage. Input words arrive on i_in (valid/ready). A word with op = 0 loads one
// weight into the table. A word with op = 1 is a pixel in raster order; it is
// written into the line stores at once. When it completes a window, a sequencer
// walks every tap of the (2R+1) x (2R+1) square, one tap per cycle through the
// single read port of the line store and one shared multiplier, and sums the taps
// inside the disc of radius R. Such a pixel holds i_in.ready low until its result
// is loaded into the output register. The result word appears on o_out
// (valid/ready) from that register; the next input word is taken while a result
// still waits, but a new result waits in the sequencer, with i_in.ready low,
// until the previous one is taken.
// Configuration is written through the APB port (width at 0x0, height at 0x4,
// radius at 0x8), only while the block is idle: a user rule the block does not enforce.
// Reset (synchronous, active low) clears the coordinates, the sequencer and the
// output valid and restores the register defaults; line stores and weights hold
// whatever they held and must be loaded before use.
module radial_kernel_image_smooth (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rks_in_if.sink      i_in,
    rks_out_if.source   o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int CB = rks_pkg::COL_BITS;
    localparam int RB = rks_pkg::ROW_BITS;
    localparam int SB = rks_pkg::SLOT_BITS;

    // Configuration registers
    logic [12:0] r_cfg_width, r_cfg_height;
    logic [3:0]  r_cfg_radius;
    logic        cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 13'(rks_pkg::MAX_WIDTH);
            r_cfg_height <= 13'(rks_pkg::MAX_HEIGHT);
            r_cfg_radius <= 4'd3;
        end else if (cfg_wr && i_paddr[1:0] == 2'b00) begin
            unique case (i_paddr[3:2])
                rks_pkg::REG_WIDTH:  r_cfg_width  <= i_pwdata[12:0];
                rks_pkg::REG_HEIGHT: r_cfg_height <= i_pwdata[12:0];
                rks_pkg::REG_RADIUS: r_cfg_radius <= i_pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            rks_pkg::REG_WIDTH:  o_prdata = {19'd0, r_cfg_width};
            rks_pkg::REG_HEIGHT: o_prdata = {19'd0, r_cfg_height};
            rks_pkg::REG_RADIUS: o_prdata = {28'd0, r_cfg_radius};
            default:             o_prdata = '0;
        endcase
    end

    // Clamped settings
    logic [12:0] eff_w, eff_h;
    logic [3:0]  eff_r;
    always_comb begin
        eff_w = (r_cfg_width == '0) ? 13'd1 :
                (r_cfg_width > 13'(rks_pkg::MAX_WIDTH)) ? 13'(rks_pkg::MAX_WIDTH) : r_cfg_width;
        eff_h = (r_cfg_height == '0) ? 13'd1 :
                (r_cfg_height > 13'(rks_pkg::MAX_HEIGHT)) ? 13'(rks_pkg::MAX_HEIGHT)
                                                          : r_cfg_height;
        eff_r = (r_cfg_radius < 4'd3) ? 4'd3 :
                (r_cfg_radius > 4'(rks_pkg::MAX_RADIUS)) ? 4'(rks_pkg::MAX_RADIUS)
                                                         : r_cfg_radius;
    end

    // Sequencer state
    rks_pkg::t_state r_state, n_state;
    logic            in_acc, pix_acc, wgt_acc, emit;
    logic            run_end, out_load;

    // Coordinates of the next pixel
    logic [CB:0]   r_col;
    logic [RB-1:0] r_row;
    logic [SB-1:0] r_rslot;
    logic [CB:0]   c0;
    logic [RB:0]   w0;
    logic [SB-1:0] s0;

    always_comb begin
        c0 = i_in.frame_start ? '0 : r_col;
        w0 = i_in.frame_start ? '0 : {1'b0, r_row};
        s0 = i_in.frame_start ? '0 : r_rslot;
        if (c0 >= (CB+1)'(eff_w)) begin
            c0 = '0;
            w0 = w0 + 1'b1;
            s0 = (s0 == SB'(rks_pkg::LINE_SLOTS - 1)) ? '0 : s0 + 1'b1;
        end
        if (w0 >= (RB+1)'(eff_h)) begin
            w0 = '0;
            s0 = '0;
        end
    end

    assign in_acc  = i_in.valid & i_in.ready;
    assign pix_acc = in_acc & (i_in.op == rks_pkg::OP_PIXEL);
    assign wgt_acc = in_acc & (i_in.op == rks_pkg::OP_WEIGHT);
    assign emit    = (c0 >= (CB+1)'({eff_r, 1'b0})) && (w0 >= (RB+1)'({eff_r, 1'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_rslot <= '0;
        end else if (pix_acc) begin
            r_col   <= c0 + 1'b1;
            r_row   <= w0[RB-1:0];
            r_rslot <= s0;
        end
    end

    // Line store and weight table
    logic [rks_pkg::PIXEL_BITS-1:0]  line_mem [0:rks_pkg::LINE_SLOTS*rks_pkg::MAX_WIDTH-1];
    logic [rks_pkg::WEIGHT_BITS-1:0] wgt_mem  [0:rks_pkg::WEIGHT_BINS-1];

    always_ff @(posedge i_clk) begin
        if (pix_acc)
            line_mem[{s0, c0[CB-1:0]}] <= i_in.pixel_value;
        if (wgt_acc && i_in.weight_index < 6'(rks_pkg::WEIGHT_BINS))
            wgt_mem[i_in.weight_index[rks_pkg::BIN_BITS-1:0]] <= i_in.weight_value;
    end

    // Per-item context
    logic [3:0]    r_rad;
    logic [CB-1:0] r_cbase, r_ocol;
    logic [RB-1:0] r_orow;
    logic [SB-1:0] r_srow;
    logic          r_last;
    logic [4:0]    r_dx, r_dy;
    logic [SB-1:0] start_slot;
    logic [SB:0]   slot_diff;

    assign slot_diff  = {1'b0, s0} - (SB+1)'({eff_r, 1'b0});
    assign start_slot = slot_diff[SB] ? SB'(slot_diff + (SB+1)'(rks_pkg::LINE_SLOTS))
                                      : slot_diff[SB-1:0];

    // Tap geometry for the current offset
    logic [4:0] adx5, ady5, two_r;
    logic [7:0] d2, r2;
    logic       tap_take;
    assign two_r    = {r_rad, 1'b0};
    assign adx5     = (r_dx > {1'b0, r_rad}) ? r_dx - {1'b0, r_rad} : {1'b0, r_rad} - r_dx;
    assign ady5     = (r_dy > {1'b0, r_rad}) ? r_dy - {1'b0, r_rad} : {1'b0, r_rad} - r_dy;
    assign d2       = 8'({4'd0, adx5[3:0]} * {4'd0, adx5[3:0]})
                    + 8'({4'd0, ady5[3:0]} * {4'd0, ady5[3:0]});
    assign r2       = 8'({4'd0, r_rad} * {4'd0, r_rad});
    assign tap_take = (r_state == rks_pkg::ST_RUN) && (d2 <= r2);
    assign run_end  = (r_dx == two_r) && (r_dy == two_r);

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_rad   <= eff_r;
            r_cbase <= CB'(c0 - (CB+1)'({eff_r, 1'b0}));
            r_ocol  <= CB'(c0 - (CB+1)'(eff_r));
            r_orow  <= RB'(w0 - (RB+1)'(eff_r));
            r_srow  <= start_slot;
            r_last  <= (c0 == (CB+1)'(eff_w - 1'b1)) && (w0 == (RB+1)'(eff_h - 1'b1));
            r_dx    <= '0;
            r_dy    <= '0;
        end else if (r_state == rks_pkg::ST_RUN) begin
            if (r_dx == two_r) begin
                r_dx   <= '0;
                r_dy   <= r_dy + 1'b1;
                r_srow <= (r_srow == SB'(rks_pkg::LINE_SLOTS - 1)) ? '0 : r_srow + 1'b1;
            end else begin
                r_dx <= r_dx + 1'b1;
            end
        end
    end

    // Read, multiply and accumulate stages
    logic                                  r_v1, r_v2;
    logic signed [rks_pkg::PIXEL_BITS-1:0] r_pix;
    logic [rks_pkg::WEIGHT_BITS-1:0]       r_wgt;
    logic signed [rks_pkg::PROD_BITS-1:0]  r_prod;
    logic signed [rks_pkg::ACC_BITS-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (tap_take) begin
            r_pix <= line_mem[{r_srow, CB'(r_cbase + CB'(r_dx))}];
            r_wgt <= wgt_mem[rks_pkg::bin_of_d2(d2)];
        end
        r_prod <= r_pix * $signed({1'b0, r_wgt});
        if (pix_acc)
            r_acc <= '0;
        else if (r_v2)
            r_acc <= r_acc + rks_pkg::ACC_BITS'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= tap_take;
            r_v2 <= r_v1;
        end
    end

    // Rounding to nearest, ties away from zero, then saturation
    logic                                 acc_neg;
    logic [rks_pkg::ACC_BITS-1:0]         acc_mag, acc_rnd;
    logic [rks_pkg::RND_BITS-1:0]         rnd;
    logic [rks_pkg::PIXEL_BITS-1:0]       res;
    localparam int PB = rks_pkg::PIXEL_BITS;

    always_comb begin
        acc_neg = r_acc[rks_pkg::ACC_BITS-1];
        acc_mag = acc_neg ? rks_pkg::ACC_BITS'(-r_acc) : rks_pkg::ACC_BITS'(r_acc);
        acc_rnd = acc_mag + (rks_pkg::ACC_BITS'(1) << (rks_pkg::WEIGHT_BITS - 1));
        rnd     = acc_rnd[rks_pkg::ACC_BITS-1:rks_pkg::WEIGHT_BITS];
        if (acc_neg) begin
            if (rnd > (rks_pkg::RND_BITS'(1) << (PB - 1)))
                res = {1'b1, {(PB-1){1'b0}}};
            else
                res = PB'(-rnd);
        end else begin
            if (rnd > rks_pkg::RND_BITS'({1'b0, {(PB-1){1'b1}}}))
                res = {1'b0, {(PB-1){1'b1}}};
            else
                res = rnd[PB-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rks_pkg::ST_IDLE:  if (pix_acc && emit) n_state = rks_pkg::ST_RUN;
            rks_pkg::ST_RUN:   if (run_end) n_state = rks_pkg::ST_DRAIN;
            rks_pkg::ST_DRAIN: if (!r_v1 && !r_v2) n_state = rks_pkg::ST_DONE;
            rks_pkg::ST_DONE:  if (!o_out.valid || o_out.ready) n_state = rks_pkg::ST_IDLE;
            default:           n_state = rks_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            rks_pkg::ST_IDLE:  i_in.ready = 1'b1;
            rks_pkg::ST_DONE:  out_load   = !o_out.valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= rks_pkg::ST_IDLE;
        else
            r_state <= n_state;
    end

    // Output register
    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (out_load)
            r_out_valid <= 1'b1;
        else if (o_out.ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out.out_col        <= r_ocol;
            o_out.out_row        <= r_orow;
            o_out.smoothed_value <= res;
            o_out.frame_last     <= r_last;
        end
    end

    assign o_out.valid = r_out_valid;

    // A product is only valid when the read stage was valid the cycle before.
    a_prod_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("product stage valid without a read");

    // The sum is complete before it is rounded.
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rks_pkg::ST_DONE) |-> (!r_v1 && !r_v2))
        else $error("result taken while taps still in flight");

    // A new result word is only ever loaded from the final state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == rks_pkg::ST_DONE))
        else $error("result valid raised outside the final state");

endmodule
